// File: rtl/core/tf_pkg.sv
// ----------------------------------------------------------------------------
// tf_pkg
// shared types, codes and widths of the uv tangent frame block
// ----------------------------------------------------------------------------
package tf_pkg;

  localparam int PosW  = 24;
  localparam int TexW  = 16;
  localparam int NrmW  = 16;
  localparam int DltW  = PosW + 1;
  localparam int TdW   = TexW + 1;
  localparam int TmagW = 42;

  localparam logic [1:0] SLOT_TARGET = 2'd0;
  localparam logic [1:0] SLOT_NEXT   = 2'd1;
  localparam logic [1:0] SLOT_PREV   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_FLAT      = 2'd2;
  localparam logic [1:0] ST_COLLINEAR = 2'd3;

  localparam logic [1:0] ADDR_ZERO_TOL = 2'd0;

  typedef struct packed {
    logic [1:0]             corner_slot;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [TexW-1:0] tex_u;
    logic signed [TexW-1:0] tex_v;
    logic signed [NrmW-1:0] norm_x;
    logic signed [NrmW-1:0] norm_y;
    logic signed [NrmW-1:0] norm_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [15:0] bin_x;
    logic signed [15:0] bin_y;
    logic signed [15:0] bin_z;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic signed [DltW-1:0] d1x;
    logic signed [DltW-1:0] d1y;
    logic signed [DltW-1:0] d1z;
    logic signed [DltW-1:0] d2x;
    logic signed [DltW-1:0] d2y;
    logic signed [DltW-1:0] d2z;
    logic signed [TdW-1:0]  du1;
    logic signed [TdW-1:0]  dv1;
    logic signed [TdW-1:0]  du2;
    logic signed [TdW-1:0]  dv2;
    logic signed [NrmW-1:0] nx;
    logic signed [NrmW-1:0] ny;
    logic signed [NrmW-1:0] nz;
  } job_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_LEN1,
    BK_LEN2,
    BK_CLASS,
    BK_DET0,
    BK_DET1,
    BK_DETCHK,
    BK_CRA,
    BK_CRB,
    BK_ALIGN,
    BK_DOT,
    BK_PROJA,
    BK_PROJB,
    BK_SUMSQ,
    BK_SQRT,
    BK_DIVLD,
    BK_DIV,
    BK_BIN,
    BK_DONE
  } bk_state_t;

endpackage

// File: rtl/core/tf_front.sv
// ----------------------------------------------------------------------------
// tf_front
// holds target and next corner, forms edge and texture deltas on the last corner
// ----------------------------------------------------------------------------
module tf_front (
  input  logic         clk,
  input  tf_pkg::in_t  beat,
  input  logic         beat_valid,
  output logic         beat_ready,
  input  logic         space,
  output logic         push,
  output tf_pkg::job_t job
);

  logic signed [tf_pkg::PosW-1:0] tgt_x, tgt_y, tgt_z, nxt_x, nxt_y, nxt_z;
  logic signed [tf_pkg::TexW-1:0] tgt_u, tgt_v, nxt_u, nxt_v;
  logic signed [tf_pkg::NrmW-1:0] nrm_x, nrm_y, nrm_z;
  logic                           accept;

  assign beat_ready = space;
  assign accept     = beat_valid && beat_ready;
  assign push       = accept && (beat.corner_slot == tf_pkg::SLOT_PREV);

  always_ff @(posedge clk) begin
    if (accept && beat.corner_slot == tf_pkg::SLOT_TARGET) begin
      tgt_x <= beat.pos_x;
      tgt_y <= beat.pos_y;
      tgt_z <= beat.pos_z;
      tgt_u <= beat.tex_u;
      tgt_v <= beat.tex_v;
      nrm_x <= beat.norm_x;
      nrm_y <= beat.norm_y;
      nrm_z <= beat.norm_z;
    end
    if (accept && beat.corner_slot == tf_pkg::SLOT_NEXT) begin
      nxt_x <= beat.pos_x;
      nxt_y <= beat.pos_y;
      nxt_z <= beat.pos_z;
      nxt_u <= beat.tex_u;
      nxt_v <= beat.tex_v;
    end
  end

  always_comb begin
    job.d1x = {nxt_x[23], nxt_x} - {tgt_x[23], tgt_x};
    job.d1y = {nxt_y[23], nxt_y} - {tgt_y[23], tgt_y};
    job.d1z = {nxt_z[23], nxt_z} - {tgt_z[23], tgt_z};
    job.d2x = {beat.pos_x[23], beat.pos_x} - {tgt_x[23], tgt_x};
    job.d2y = {beat.pos_y[23], beat.pos_y} - {tgt_y[23], tgt_y};
    job.d2z = {beat.pos_z[23], beat.pos_z} - {tgt_z[23], tgt_z};
    job.du1 = {nxt_u[15], nxt_u} - {tgt_u[15], tgt_u};
    job.dv1 = {nxt_v[15], nxt_v} - {tgt_v[15], tgt_v};
    job.du2 = {beat.tex_u[15], beat.tex_u} - {tgt_u[15], tgt_u};
    job.dv2 = {beat.tex_v[15], beat.tex_v} - {tgt_v[15], tgt_v};
    job.nx  = nrm_x;
    job.ny  = nrm_y;
    job.nz  = nrm_z;
  end

endmodule

// File: rtl/core/tf_queue.sv
// ----------------------------------------------------------------------------
// tf_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module tf_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tf_pkg::job_t wdata,
  output logic         full,
  input  logic         pop,
  output tf_pkg::job_t rdata,
  output logic         empty
);

  tf_pkg::job_t mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/tf_back.sv
// ----------------------------------------------------------------------------
// tf_back
// sequenced tangent solve, projection, bit-serial sqrt and divide, binormal
// ----------------------------------------------------------------------------
module tf_back (
  input  logic         clk,
  input  logic         rst,
  input  tf_pkg::job_t job,
  input  logic         job_valid,
  output logic         pop,
  input  logic [15:0]  tol,
  output tf_pkg::out_t res,
  output logic         res_valid,
  input  logic         res_ready
);

  tf_pkg::bk_state_t state, state_next;
  tf_pkg::job_t      j;

  logic [1:0]               cnt;
  logic [49:0]              l1, l2;
  logic signed [34:0]       det;
  logic signed [41:0]       cp;
  logic [41:0]              tm [3];
  logic                     ts [3];
  logic                     pass;
  logic signed [47:0]       dot;
  logic signed [63:0]       pm;
  logic [61:0]              sum;
  logic [62:0]              sx, sr, sbit;
  logic [30:0]              len;
  logic [30:0]              rem;
  logic [14:0]              nsh, q;
  logic [3:0]               step;
  logic signed [15:0]       tq [3];
  logic signed [15:0]       bq [3];
  logic [1:0]               status;

  logic signed [24:0] d1v [3];
  logic signed [24:0] d2v [3];
  logic signed [15:0] nv [3];
  logic signed [24:0] d1s, d2s;
  logic signed [15:0] ns;
  logic signed [49:0] sq1, sq2;
  logic [31:0]        tol2;
  logic [16:0]        adv1, adu1;
  logic signed [33:0] pd0, pd1;
  logic [34:0]        adet;
  logic signed [41:0] pb, pa;
  logic signed [42:0] cv;
  logic [42:0]        cabs;
  logic [41:0]        mx;
  logic signed [31:0] tsig;
  logic signed [47:0] dprod;
  logic signed [63:0] pprod;
  logic [63:0]        pmag;
  logic [35:0]        rmag;
  logic signed [36:0] rsig;
  logic signed [37:0] nt;
  logic [37:0]        ntabs;
  logic [59:0]        sqv;
  logic [61:0]        sum_n;
  logic [62:0]        strial;
  logic               sge;
  logic [44:0]        num;
  logic [31:0]        dtrial;
  logic               dge;
  logic [14:0]        qn;
  logic [1:0]         ia, ib;
  logic signed [32:0] xv;
  logic [32:0]        xm;
  logic [19:0]        rbm;
  logic signed [15:0] bsat;
  logic               short_edge, len_ok;

  always_comb begin
    d1v[0] = j.d1x; d1v[1] = j.d1y; d1v[2] = j.d1z;
    d2v[0] = j.d2x; d2v[1] = j.d2y; d2v[2] = j.d2z;
    nv[0]  = j.nx;  nv[1]  = j.ny;  nv[2]  = j.nz;
    d1s    = d1v[cnt];
    d2s    = d2v[cnt];
    ns     = nv[cnt];
    sq1    = d1s * d1s;
    sq2    = d2s * d2s;
    tol2   = tol * tol;
    adv1   = j.dv1[16] ? 17'(-j.dv1) : 17'(j.dv1);
    adu1   = j.du1[16] ? 17'(-j.du1) : 17'(j.du1);
    short_edge = (l1 < 50'(tol2)) || (l2 < 50'(tol2));
    pd0    = j.dv1 * j.du2;
    pd1    = j.dv2 * j.du1;
    adet   = det[34] ? 35'(-det) : 35'(det);
    pa     = j.dv1 * d2s;
    pb     = j.dv2 * d1s;
    cv     = cp - pb;
    cabs   = cv[42] ? 43'(-cv) : 43'(cv);
    mx     = tm[0];
    if (tm[1] > mx) begin
      mx = tm[1];
    end
    if (tm[2] > mx) begin
      mx = tm[2];
    end
    tsig   = ts[cnt] ? -$signed({2'b00, tm[cnt][29:0]}) : $signed({2'b00, tm[cnt][29:0]});
    dprod  = ns * tsig;
    pprod  = dot * ns;
    pmag   = pm[63] ? 64'(-pm) : 64'(pm);
    rmag   = 36'((pmag + 64'(1 << 27)) >> 28);
    rsig   = pm[63] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    nt     = tsig - rsig;
    ntabs  = nt[37] ? 38'(-nt) : 38'(nt);
    sqv    = tm[cnt][29:0] * tm[cnt][29:0];
    sum_n  = sum + 62'(sqv);
    strial = sr + sbit;
    sge    = (sx >= strial);
    num    = {1'b0, tm[cnt][29:0], 14'b0} + 45'(len[30:1]);
    dtrial = {rem, nsh[14]};
    dge    = (dtrial >= {1'b0, len});
    qn     = {q[13:0], dge};
    case (cnt)
      2'd0:    begin ia = 2'd1; ib = 2'd2; end
      2'd1:    begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
    xv     = (nv[ia] * tq[ib]) - (nv[ib] * tq[ia]);
    xm     = xv[32] ? 33'(-xv) : 33'(xv);
    rbm    = 20'((xm + 33'(1 << 13)) >> 14);
    if (!xv[32]) begin
      bsat = (rbm > 20'd32767) ? 16'sd32767 : $signed(rbm[15:0]);
    end else begin
      bsat = (rbm > 20'd32768) ? -16'sd32768 : -$signed(rbm[15:0]);
    end
    len_ok = (sbit == 63'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      tf_pkg::BK_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = tf_pkg::BK_LEN1;
        end
      end
      tf_pkg::BK_LEN1: begin
        if (cnt == 2'd2) state_next = tf_pkg::BK_LEN2;
      end
      tf_pkg::BK_LEN2: begin
        if (cnt == 2'd2) state_next = tf_pkg::BK_CLASS;
      end
      tf_pkg::BK_CLASS: begin
        if (short_edge) begin
          state_next = tf_pkg::BK_DONE;
        end else if (adv1 < {1'b0, tol}) begin
          state_next = (adu1 < {1'b0, tol}) ? tf_pkg::BK_DONE : tf_pkg::BK_ALIGN;
        end else begin
          state_next = tf_pkg::BK_DET0;
        end
      end
      tf_pkg::BK_DET0: state_next = tf_pkg::BK_DET1;
      tf_pkg::BK_DET1: state_next = tf_pkg::BK_DETCHK;
      tf_pkg::BK_DETCHK: begin
        if (adet < 35'(tol) || det == 35'sd0) begin
          state_next = tf_pkg::BK_DONE;
        end else begin
          state_next = tf_pkg::BK_CRA;
        end
      end
      tf_pkg::BK_CRA: state_next = tf_pkg::BK_CRB;
      tf_pkg::BK_CRB: begin
        state_next = (cnt == 2'd2) ? tf_pkg::BK_ALIGN : tf_pkg::BK_CRA;
      end
      tf_pkg::BK_ALIGN: begin
        if (mx == 42'd0) begin
          state_next = tf_pkg::BK_DONE;
        end else if (mx[41:30] == 12'd0 && mx[29]) begin
          state_next = pass ? tf_pkg::BK_SUMSQ : tf_pkg::BK_DOT;
        end
      end
      tf_pkg::BK_DOT: begin
        if (cnt == 2'd2) state_next = tf_pkg::BK_PROJA;
      end
      tf_pkg::BK_PROJA: state_next = tf_pkg::BK_PROJB;
      tf_pkg::BK_PROJB: begin
        state_next = (cnt == 2'd2) ? tf_pkg::BK_ALIGN : tf_pkg::BK_PROJA;
      end
      tf_pkg::BK_SUMSQ: begin
        if (cnt == 2'd2) state_next = tf_pkg::BK_SQRT;
      end
      tf_pkg::BK_SQRT: begin
        if (len_ok) state_next = tf_pkg::BK_DIVLD;
      end
      tf_pkg::BK_DIVLD: state_next = tf_pkg::BK_DIV;
      tf_pkg::BK_DIV: begin
        if (step == 4'd14) begin
          state_next = (cnt == 2'd2) ? tf_pkg::BK_BIN : tf_pkg::BK_DIVLD;
        end
      end
      tf_pkg::BK_BIN: begin
        if (cnt == 2'd2) state_next = tf_pkg::BK_DONE;
      end
      tf_pkg::BK_DONE: begin
        if (!res_valid || res_ready) state_next = tf_pkg::BK_IDLE;
      end
      default: state_next = tf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case (state)
        tf_pkg::BK_IDLE, tf_pkg::BK_CLASS, tf_pkg::BK_DETCHK, tf_pkg::BK_ALIGN: begin
          cnt <= 2'd0;
        end
        tf_pkg::BK_LEN1, tf_pkg::BK_LEN2, tf_pkg::BK_DOT, tf_pkg::BK_SUMSQ,
        tf_pkg::BK_BIN, tf_pkg::BK_CRB, tf_pkg::BK_PROJB: begin
          cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        end
        tf_pkg::BK_DIV: begin
          if (step == 4'd14) cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        end
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tf_pkg::BK_IDLE: begin
        j    <= job;
        l1   <= '0;
        l2   <= '0;
        pass <= 1'b0;
      end
      tf_pkg::BK_LEN1: l1 <= l1 + $unsigned(sq1);
      tf_pkg::BK_LEN2: l2 <= l2 + $unsigned(sq2);
      tf_pkg::BK_CLASS: begin
        for (int i = 0; i < 3; i++) begin
          tq[i] <= '0;
          bq[i] <= '0;
          tm[i] <= 42'(d1v[i][24] ? 25'(-d1v[i]) : 25'(d1v[i]));
          ts[i] <= d1v[i][24] ^ j.du1[16];
        end
        if (short_edge) begin
          status <= tf_pkg::ST_SHORT;
        end else if (adv1 < {1'b0, tol} && adu1 < {1'b0, tol}) begin
          status <= tf_pkg::ST_FLAT;
        end else begin
          status <= tf_pkg::ST_OK;
        end
      end
      tf_pkg::BK_DET0: det <= 35'(pd0);
      tf_pkg::BK_DET1: det <= det - 35'(pd1);
      tf_pkg::BK_DETCHK: begin
        if (adet < 35'(tol) || det == 35'sd0) status <= tf_pkg::ST_COLLINEAR;
      end
      tf_pkg::BK_CRA: cp <= pa;
      tf_pkg::BK_CRB: begin
        tm[cnt] <= cabs[41:0];
        ts[cnt] <= cv[42] ^ det[34];
      end
      tf_pkg::BK_ALIGN: begin
        dot <= '0;
        sum <= '0;
        for (int i = 0; i < 3; i++) begin
          if (mx[41:38] != 4'd0) begin
            tm[i] <= tm[i] >> 8;
          end else if (mx[41:30] != 12'd0) begin
            tm[i] <= tm[i] >> 1;
          end else if (mx[41:21] == 21'd0) begin
            tm[i] <= tm[i] << 8;
          end else if (!mx[29]) begin
            tm[i] <= tm[i] << 1;
          end
        end
      end
      tf_pkg::BK_DOT: dot <= dot + dprod;
      tf_pkg::BK_PROJA: pm <= pprod;
      tf_pkg::BK_PROJB: begin
        tm[cnt] <= 42'(ntabs);
        ts[cnt] <= nt[37];
        if (cnt == 2'd2) pass <= 1'b1;
      end
      tf_pkg::BK_SUMSQ: begin
        sum <= sum_n;
        if (cnt == 2'd2) begin
          sx   <= 63'(sum_n);
          sr   <= '0;
          sbit <= 63'(1) << 62;
        end
      end
      tf_pkg::BK_SQRT: begin
        if (sge) begin
          sx <= sx - strial;
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
        if (len_ok) len <= sge ? 31'((sr >> 1) + sbit) : 31'(sr >> 1);
      end
      tf_pkg::BK_DIVLD: begin
        rem  <= 31'(num[44:15]);
        nsh  <= num[14:0];
        q    <= '0;
        step <= '0;
      end
      tf_pkg::BK_DIV: begin
        rem  <= dge ? 31'(dtrial - {1'b0, len}) : dtrial[30:0];
        nsh  <= nsh << 1;
        q    <= qn;
        step <= step + 4'd1;
        if (step == 4'd14) begin
          tq[cnt] <= ts[cnt] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
        end
      end
      tf_pkg::BK_BIN: bq[cnt] <= bsat;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == tf_pkg::BK_DONE && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tf_pkg::BK_DONE && (!res_valid || res_ready)) begin
      res.tan_x  <= tq[0];
      res.tan_y  <= tq[1];
      res.tan_z  <= tq[2];
      res.bin_x  <= bq[0];
      res.bin_y  <= bq[1];
      res.bin_z  <= bq[2];
      res.status <= status;
    end
  end

endmodule

// File: rtl/core/uv_tangent_frame.sv
// ----------------------------------------------------------------------------
// uv_tangent_frame
// tangent and binormal at a triangle corner from positions and texture coords
// ----------------------------------------------------------------------------
// corners 0 and 1 are held in the front; corner 2 queues a job for the back end
// most of a job is the 32-step square root and three 15-step divides; the
// 2-deep job queue lets the front keep taking beats while the queue has room
// result is registered at the end of a job once the output is free, held until taken
// reset clears control and sets zero_tolerance to 1; held corners undefined
// ----------------------------------------------------------------------------
module uv_tangent_frame (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  tf_pkg::in_t  corner,
  input  logic         corner_valid,
  output logic         corner_ready,
  output tf_pkg::out_t frame,
  output logic         frame_valid,
  input  logic         frame_ready
);

  logic [15:0]  zero_tolerance;
  logic         push, full, empty, pop;
  tf_pkg::job_t job_in, job_out;

  assign pready = 1'b1;
  assign prdata = (paddr == tf_pkg::ADDR_ZERO_TOL) ? {16'b0, zero_tolerance} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      zero_tolerance <= pwdata[15:0];
    end
  end

  tf_front u_front (
    .clk        (clk),
    .beat       (corner),
    .beat_valid (corner_valid),
    .beat_ready (corner_ready),
    .space      (!full),
    .push       (push),
    .job        (job_in)
  );

  tf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (pop),
    .rdata (job_out),
    .empty (empty)
  );

  tf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_valid (!empty),
    .pop       (pop),
    .tol       (zero_tolerance),
    .res       (frame),
    .res_valid (frame_valid),
    .res_ready (frame_ready)
  );

endmodule

// File: test/uv_tangent_frame_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_tangent_frame_check
// watches the corner, frame and register ports of the tangent frame block,
// predicts every frame from the accepted corners and compares field by field
// ----------------------------------------------------------------------------
module uv_tangent_frame_check
  import tf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  in_t         corner,
  input  logic        corner_valid,
  input  logic        corner_ready,
  input  out_t        frame,
  input  logic        frame_valid,
  input  logic        frame_ready,
  output int          mismatches,
  output int          pending,
  output int          frames_seen
);

  typedef longint vec3_t [3];

  longint unsigned tol;
  longint          hold_pos [6];
  longint          hold_tex [4];
  longint          hold_nrm [3];
  out_t            frame_q [$];

  function automatic longint unsigned umag(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_shift(longint x, int k);
    longint unsigned m;
    m = (umag(x) + (64'd1 << (k - 1))) >> k;
    return with_sign(m, x < 0);
  endfunction

  function automatic bit normalize_range(inout vec3_t v);
    longint unsigned m, a;
    int up, dn;
    m = 0;
    up = 0;
    dn = 0;
    for (int i = 0; i < 3; i++) if (umag(v[i]) > m) m = umag(v[i]);
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      dn++;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      up++;
    end
    for (int i = 0; i < 3; i++) begin
      a = (umag(v[i]) >> dn) << up;
      v[i] = with_sign(a, v[i] < 0);
    end
    return 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic out_t tangent_frame(in_t c);
    vec3_t d1, d2, t, b;
    longint p [3];
    longint du1, dv1, du2, dv2, det, dot;
    longint unsigned l1, l2, tol2, len, sum, q;
    logic [1:0] st;
    out_t r;
    l1 = 0;
    l2 = 0;
    sum = 0;
    st = ST_OK;
    p[0] = c.pos_x;
    p[1] = c.pos_y;
    p[2] = c.pos_z;
    for (int i = 0; i < 3; i++) begin
      t[i] = 0;
      b[i] = 0;
      d1[i] = hold_pos[3+i] - hold_pos[i];
      d2[i] = p[i] - hold_pos[i];
      l1 += umag(d1[i]) * umag(d1[i]);
      l2 += umag(d2[i]) * umag(d2[i]);
    end
    tol2 = tol * tol;
    du1 = hold_tex[2] - hold_tex[0];
    dv1 = hold_tex[3] - hold_tex[1];
    du2 = longint'(c.tex_u) - hold_tex[0];
    dv2 = longint'(c.tex_v) - hold_tex[1];
    if (l1 < tol2 || l2 < tol2) begin
      st = ST_SHORT;
    end else if (umag(dv1) < tol) begin
      if (umag(du1) < tol) st = ST_FLAT;
      else for (int i = 0; i < 3; i++) t[i] = du1 < 0 ? -d1[i] : d1[i];
    end else begin
      det = dv1 * du2 - dv2 * du1;
      if (umag(det) < tol || det == 0) st = ST_COLLINEAR;
      else for (int i = 0; i < 3; i++) begin
        t[i] = dv1 * d2[i] - dv2 * d1[i];
        if (det < 0) t[i] = -t[i];
      end
    end
    if (st == ST_OK && normalize_range(t)) begin
      dot = hold_nrm[0] * t[0] + hold_nrm[1] * t[1] + hold_nrm[2] * t[2];
      for (int i = 0; i < 3; i++) t[i] -= round_shift(dot * hold_nrm[i], 28);
      if (normalize_range(t)) begin
        for (int i = 0; i < 3; i++) sum += umag(t[i]) * umag(t[i]);
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          q = (umag(t[i]) * 16384 + len / 2) / len;
          t[i] = with_sign(q, t[i] < 0);
        end
        b[0] = clamp16(round_shift(hold_nrm[1] * t[2] - hold_nrm[2] * t[1], 14));
        b[1] = clamp16(round_shift(hold_nrm[2] * t[0] - hold_nrm[0] * t[2], 14));
        b[2] = clamp16(round_shift(hold_nrm[0] * t[1] - hold_nrm[1] * t[0], 14));
      end
    end else begin
      for (int i = 0; i < 3; i++) t[i] = 0;
    end
    r.tan_x = t[0][15:0];
    r.tan_y = t[1][15:0];
    r.tan_z = t[2][15:0];
    r.bin_x = b[0][15:0];
    r.bin_y = b[1][15:0];
    r.bin_z = b[2][15:0];
    r.status = st;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got, inout int errs);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      errs++;
    end
  endtask

  always @(posedge clk) begin
    int errs;
    out_t want;
    errs = 0;
    if (rst) begin
      tol = 1;
      frame_q.delete();
      mismatches <= 0;
      frames_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_ZERO_TOL) tol = pwdata[15:0];
      if (corner_valid && corner_ready) begin
        case (corner.corner_slot)
          SLOT_TARGET: begin
            hold_pos[0] = corner.pos_x;
            hold_pos[1] = corner.pos_y;
            hold_pos[2] = corner.pos_z;
            hold_tex[0] = corner.tex_u;
            hold_tex[1] = corner.tex_v;
            hold_nrm[0] = corner.norm_x;
            hold_nrm[1] = corner.norm_y;
            hold_nrm[2] = corner.norm_z;
          end
          SLOT_NEXT: begin
            hold_pos[3] = corner.pos_x;
            hold_pos[4] = corner.pos_y;
            hold_pos[5] = corner.pos_z;
            hold_tex[2] = corner.tex_u;
            hold_tex[3] = corner.tex_v;
          end
          SLOT_PREV: frame_q.push_back(tangent_frame(corner));
          default: ;
        endcase
      end
      if (frame_valid && frame_ready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: frame beat with nothing expected, got %p", $time, frame);
          errs++;
        end else begin
          want = frame_q.pop_front();
          check_field("tan_x", want.tan_x, frame.tan_x, errs);
          check_field("tan_y", want.tan_y, frame.tan_y, errs);
          check_field("tan_z", want.tan_z, frame.tan_z, errs);
          check_field("bin_x", want.bin_x, frame.bin_x, errs);
          check_field("bin_y", want.bin_y, frame.bin_y, errs);
          check_field("bin_z", want.bin_z, frame.bin_z, errs);
          check_field("status", 16'(want.status), 16'(frame.status), errs);
        end
        frames_seen <= frames_seen + 1;
      end
      mismatches <= mismatches + errs;
    end
    pending <= frame_q.size();
  end

endmodule

// File: test/uv_tangent_frame_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_tangent_frame_test
// drives corner sets and register writes into the tangent frame block under
// several idle and stall mixes; the checker predicts and compares each frame
// ----------------------------------------------------------------------------
module uv_tangent_frame_test;
  import tf_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  in_t         corner = '0;
  logic        corner_valid = 0;
  logic        corner_ready;
  out_t        frame;
  logic        frame_valid;
  logic        frame_ready = 0;
  int          mismatches, pending, frames_seen;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          corners_sent = 0;

  uv_tangent_frame DUT (.*);

  uv_tangent_frame_check checker_i (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) frame_ready <= ($urandom_range(99) >= recv_stall);

  task automatic put_corner(in_t c);
    corner <= c;
    corner_valid <= 1;
    @(posedge clk);
    while (!corner_ready) @(posedge clk);
    corners_sent++;
    if ($urandom_range(99) < send_idle) begin
      corner_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic reg_write(logic [15:0] val);
    corner_valid <= 0;
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_ZERO_TOL;
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain();
    corner_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic in_t mk(logic [1:0] s, int x, int y, int z, int u, int v,
                             int nx = 0, int ny = 0, int nz = 16384);
    in_t c;
    c.corner_slot = s;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    c.tex_u = u;
    c.tex_v = v;
    c.norm_x = nx;
    c.norm_y = ny;
    c.norm_z = nz;
    return c;
  endfunction

  function automatic in_t rand_corner(logic [1:0] s);
    in_t c;
    c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c.corner_slot = s;
    if ($urandom_range(3) != 0) begin
      c.pos_x = $signed(c.pos_x) >>> $urandom_range(12);
      c.pos_y = $signed(c.pos_y) >>> $urandom_range(12);
      c.pos_z = $signed(c.pos_z) >>> $urandom_range(12);
    end
    if (s == SLOT_TARGET && $urandom_range(1)) begin
      c.norm_x = 0;
      c.norm_y = 0;
      c.norm_z = 0;
      case ($urandom_range(2))
        0: c.norm_x = $urandom_range(1) ? 16384 : -16384;
        1: c.norm_y = $urandom_range(1) ? 16384 : -16384;
        default: begin
          c.norm_x = 11585;
          c.norm_z = $urandom_range(1) ? 11585 : -11585;
        end
      endcase
    end
    return c;
  endfunction

  task automatic rand_set();
    int r;
    r = $urandom_range(19);
    if (r == 0) put_corner(rand_corner(2'd3));
    else if (r == 1) put_corner(rand_corner(SLOT_PREV));
    else if (r == 2) put_corner(rand_corner(SLOT_NEXT));
    else begin
      put_corner(rand_corner(SLOT_TARGET));
      put_corner(rand_corner(SLOT_NEXT));
      put_corner(rand_corner(SLOT_PREV));
    end
  endtask

  initial begin
    logic [15:0] tols [4];
    int idles [4];
    int stalls [4];
    tols = '{16'd0, 16'd65535, 16'd1, 16'd37};
    idles = '{0, 50, 0, 28};
    stalls = '{0, 0, 50, 28};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // basic, vanishing tangent, short edge, flat texture, collinear texture, stray slot 3 and repeated last corners
    put_corner(mk(SLOT_TARGET, 0, 0, 0, 0, 0));
    put_corner(mk(SLOT_NEXT, 4096, 0, 0, 4096, 0));
    put_corner(mk(SLOT_PREV, 0, 4096, 0, 0, 4096));
    put_corner(mk(SLOT_TARGET, 0, 0, 0, 0, 0, 16384, 0, 0));
    put_corner(mk(SLOT_NEXT, 4096, 0, 0, 4096, 0));
    put_corner(mk(SLOT_PREV, 0, 4096, 0, 0, 4096));
    put_corner(mk(SLOT_TARGET, 5, 5, 5, 0, 0));
    put_corner(mk(SLOT_NEXT, 5, 5, 5, 100, 0));
    put_corner(mk(SLOT_PREV, 0, 4096, 0, 0, 4096));
    put_corner(mk(SLOT_TARGET, 0, 0, 0, 7, 7, -32768, 32767, -32768));
    put_corner(mk(SLOT_NEXT, 8388607, -8388608, 8388607, 7, 7));
    put_corner(mk(SLOT_PREV, -8388608, 8388607, -8388608, 1000, 0));
    put_corner(mk(SLOT_TARGET, -8388608, -8388608, -8388608, -32768, -32768, 32767, 32767, 32767));
    put_corner(mk(SLOT_NEXT, 8388607, 8388607, 0, 32767, 32767));
    put_corner(mk(SLOT_PREV, 0, 8388607, 8388607, 0, 0));
    put_corner(mk(2'd3, 1, 2, 3, 4, 5));
    put_corner(mk(SLOT_PREV, 1000, -2000, 3000, -32768, 32767));
    put_corner(mk(SLOT_PREV, 7, 9000, -400, 5, -9));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(tols[ph]);
      send_idle = idles[ph];
      recv_stall = stalls[ph];
      if (ph == 0) begin
        put_corner(mk(SLOT_TARGET, 0, 0, 0, 0, 0));
        put_corner(mk(SLOT_NEXT, 4096, 0, 0, 4096, 2));
        put_corner(mk(SLOT_PREV, 0, 4096, 0, 8192, 4));
      end
      for (int k = 0; k < 85; k++) begin
        if (k % 40 == 39) drain();
        rand_set();
      end
      drain();
    end

    $display("sent %0d corners over four register settings and idle mixes", corners_sent);
    $display("checked %0d frames against the predicted tangent frames", frames_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
